// ===== rtl/sols_pkg.sv =====
// Shared constants for the self-organizing list search block.
package sols_pkg;

    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int IN_KEY_W = 32;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_FOUND    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_APPENDED = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

    // Operation codes
    localparam logic OP_SEARCH = 1'b0;
    localparam logic OP_APPEND = 1'b1;

    // Reorder methods
    localparam logic METHOD_MTF       = 1'b0;
    localparam logic METHOD_TRANSPOSE = 1'b1;

endpackage

// ===== rtl/sols_table.sv =====
// Key table storage: one write port, one read port with registered read data.
module sols_table #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32,
    parameter int IDX_W     = 4
) (
    input  logic                 aclk,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output logic [KEY_WIDTH-1:0] rd_data,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  logic [KEY_WIDTH-1:0] wr_data
);

    logic [KEY_WIDTH-1:0] mem [DEPTH];
    logic [KEY_WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/self_organizing_list_search.sv =====
// Self-organizing list search: serial scan of a key table with move-to-front or transpose.
// Append answers without a scan; a search scans from the head, and a hit past the head shifts, then places the key.
//   The scan reads one entry a cycle; each move-to-front shift cycle reads and writes one entry.
// One transaction at a time; the scan and the shift share the single table read port.
// Synchronous active-low reset clears count, method and handshake state; table is not cleared.
module self_organizing_list_search #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic [sols_pkg::IN_KEY_W-1:0] s_key,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sols_pkg::STATUS_W-1:0] m_status,
    output logic [sols_pkg::POS_W-1:0]    m_position
);

    import sols_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_SHIFT = 3'd2;
    localparam logic [2:0] ST_PLACE = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    // Index to the position field width (masked or zero-extended)
    function automatic logic [POS_W-1:0] to_pos(input logic [IDX_W-1:0] idx);
        logic [IDX_W+POS_W-1:0] wide;
        wide = {{POS_W{1'b0}}, idx};
        return wide[POS_W-1:0];
    endfunction

    // Input key to the table key width
    function automatic logic [KEY_WIDTH-1:0] to_key(input logic [IN_KEY_W-1:0] k);
        logic [IN_KEY_W+KEY_WIDTH-1:0] wide;
        wide = {{KEY_WIDTH{1'b0}}, k};
        return wide[KEY_WIDTH-1:0];
    endfunction

    logic [2:0]           state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic                 method_reg;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [POS_W-1:0]     res_pos_reg, res_pos_next;
    logic                 m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [POS_W-1:0]     m_position_reg, m_position_next;

    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [KEY_WIDTH-1:0] rd_data;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [KEY_WIDTH-1:0] wr_data;
    logic                 s_fire;
    logic                 last_entry;

    sols_table #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH),
        .IDX_W     (IDX_W)
    ) u_table (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign last_entry = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    // Sequencer: scan, shift, place, deliver
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_position_next = m_position_reg;
        rd_en           = 1'b0;
        rd_addr         = idx_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = key_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    key_next   = to_key(s_key);
                    state_next = ST_DONE;
                    if (s_operation == OP_APPEND) begin
                        if (count_reg == CNT_W'(DEPTH)) begin
                            res_status_next = STATUS_FULL;
                            res_pos_next    = '0;
                        end else begin
                            wr_en           = 1'b1;
                            wr_addr         = count_reg[IDX_W-1:0];
                            wr_data         = to_key(s_key);
                            count_next      = count_reg + CNT_W'(1);
                            res_status_next = STATUS_APPENDED;
                            res_pos_next    = to_pos(count_reg[IDX_W-1:0]);
                        end
                    end else if (count_reg == '0) begin
                        res_status_next = STATUS_MISS;
                        res_pos_next    = '0;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // rd_data holds the entry at idx_reg
                if (rd_data == key_reg) begin
                    if (idx_reg == '0) begin
                        res_status_next = STATUS_FOUND;
                        res_pos_next    = '0;
                        state_next      = ST_DONE;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = idx_reg - IDX_W'(1);
                        state_next = ST_SHIFT;
                    end
                end else if (last_entry) begin
                    res_status_next = STATUS_MISS;
                    res_pos_next    = '0;
                    state_next      = ST_DONE;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + IDX_W'(1);
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_SHIFT: begin
                // Move the predecessor back one slot
                wr_en    = 1'b1;
                wr_addr  = idx_reg;
                wr_data  = rd_data;
                idx_next = idx_reg - IDX_W'(1);
                if ((method_reg == METHOD_MTF) && (idx_reg > IDX_W'(1))) begin
                    rd_en   = 1'b1;
                    rd_addr = idx_reg - IDX_W'(2);
                end else begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE: begin
                wr_en           = 1'b1;
                wr_addr         = idx_reg;
                wr_data         = key_reg;
                res_status_next = STATUS_FOUND;
                res_pos_next    = to_pos(idx_reg);
                state_next      = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_status_next   = res_status_reg;
                    m_position_next = res_pos_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            method_reg  <= METHOD_MTF;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                method_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        m_status_reg   <= m_status_next;
        m_position_reg <= m_position_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_position = m_position_reg;

    // Entry count stays within the table
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond table depth");

    // Count moves only on an appended transaction
    a_count_append: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_fire && (s_operation == OP_APPEND)) |=> $stable(count_reg))
        else $error("entry count changed without append");

    // Scan never passes the filled part of the table
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (CNT_W'(idx_reg) < count_reg))
        else $error("scan index beyond entry count");

    // Shift only runs on a hit past the head
    a_shift_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT) |-> ((idx_reg != '0) && (CNT_W'(idx_reg) < count_reg)))
        else $error("shift index out of range");

    // An accepted transaction holds off the next one
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready)
        else $error("input taken while busy");

endmodule

// ===== bench/tb_self_organizing_list_search.sv =====
// Testbench for the self-organizing list search block: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_self_organizing_list_search;
    import sols_pkg::*;

    localparam int TABLE_DEPTH      = 16;
    localparam int RANDOM_PHASES    = 6;
    localparam int RANDOM_PER_PHASE = 312;
    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int DRAIN_CYCLES     = 2 * TABLE_DEPTH + 8;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
    } lookup_result_t;

    typedef struct {
        bit                  cfg_write;
        logic                cfg_method;
        logic                op;
        logic [IN_KEY_W-1:0] key;
        bit                  typed;
        lookup_result_t      typed_result;
    } stim_row_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic                cfg_wr_data;
    logic                s_valid;
    logic                s_ready;
    logic                s_operation;
    logic [IN_KEY_W-1:0] s_key;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [POS_W-1:0]    m_position;

    // Shadow copy of the block's table and register
    logic [IN_KEY_W-1:0] shadow_keys [TABLE_DEPTH];
    int                  shadow_count;
    logic                shadow_method;

    lookup_result_t pending_results [$];
    stim_row_t      directed_rows [$];
    lookup_result_t head_result;
    int             error_count;
    int             quiet_cycles;

    // Receiver stall pattern state
    int rx_mode;
    int rx_left;
    int rx_stall_run;
    int rx_cycle;

    self_organizing_list_search #(
        .DEPTH(TABLE_DEPTH),
        .KEY_WIDTH(IN_KEY_W)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_operation(s_operation),
        .s_key(s_key),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_position(m_position)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Apply one operation to the shadow table and work out its result
    task automatic update_shadow_table(input logic op, input logic [IN_KEY_W-1:0] key,
                                       output lookup_result_t res);
        int hit;
        int i;
        int j;
        res.status   = STATUS_MISS;
        res.position = '0;
        if (op == OP_APPEND) begin
            if (shadow_count >= TABLE_DEPTH) begin
                res.status = STATUS_FULL;
            end else begin
                shadow_keys[shadow_count] = key;
                res.status   = STATUS_APPENDED;
                res.position = POS_W'(shadow_count);
                shadow_count++;
            end
        end else begin
            hit = -1;
            for (i = 0; i < shadow_count; i++) begin
                if (hit < 0 && shadow_keys[i] == key) hit = i;
            end
            if (hit >= 0) begin
                res.status = STATUS_FOUND;
                if (hit > 0) begin
                    if (shadow_method == METHOD_MTF) begin
                        for (j = hit; j > 0; j--) shadow_keys[j] = shadow_keys[j-1];
                        shadow_keys[0] = key;
                    end else begin
                        shadow_keys[hit]   = shadow_keys[hit-1];
                        shadow_keys[hit-1] = key;
                        res.position       = POS_W'(hit - 1);
                    end
                end
            end
        end
    endtask

    task automatic add_row(input bit cfg_write, input logic cfg_method, input logic op,
                           input logic [IN_KEY_W-1:0] key, input bit typed,
                           input logic [STATUS_W-1:0] st, input logic [POS_W-1:0] pos);
        stim_row_t row;
        row.cfg_write             = cfg_write;
        row.cfg_method            = cfg_method;
        row.op                    = op;
        row.key                   = key;
        row.typed                 = typed;
        row.typed_result.status   = st;
        row.typed_result.position = pos;
        directed_rows.push_back(row);
    endtask

    // Offer one transaction and hold it until accepted
    task automatic send_lookup(input logic op, input logic [IN_KEY_W-1:0] key, input bit typed,
                               input lookup_result_t typed_result);
        lookup_result_t predicted;
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_operation <= op;
        s_key       <= key;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        update_shadow_table(op, key, predicted);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            @(negedge aclk);
            s_valid     <= 1'b0;
            s_operation <= 1'($urandom);
            s_key       <= $urandom;
            repeat (cycles - 1) @(negedge aclk);
        end
    endtask

    // Method change only once the block has drained
    task automatic set_method(input logic method);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en     <= 1'b1;
        cfg_wr_data   <= method;
        shadow_method = method;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Receiver: ready pattern switches between several modes
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(40, 200);
        end
        rx_left--;
        rx_cycle++;
        case (rx_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                if (rx_stall_run > 0) begin
                    rx_stall_run--;
                    m_ready <= 1'b0;
                end else if ($urandom_range(0, 7) == 0) begin
                    rx_stall_run = $urandom_range(5, 25);
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
            default: begin
                m_ready <= (rx_cycle % 3 == 0);
            end
        endcase
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d position %0d", m_status, m_position);
                error_count++;
            end else begin
                head_result = pending_results.pop_front();
                if (m_status !== head_result.status) begin
                    $error("status mismatch: expected %0d actual %0d",
                           head_result.status, m_status);
                    error_count++;
                end
                if (m_position !== head_result.position) begin
                    $error("position mismatch: expected %0d actual %0d",
                           head_result.position, m_position);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin : main
        int             r;
        int             i;
        int             phase;
        int             sent;
        int             burst;
        int             k;
        int             sel;
        logic           op;
        logic [IN_KEY_W-1:0] key;
        lookup_result_t no_result;

        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        s_valid       = 1'b0;
        s_operation   = OP_SEARCH;
        s_key         = '0;
        shadow_count  = 0;
        shadow_method = METHOD_MTF;
        error_count   = 0;
        quiet_cycles  = 0;
        rx_mode       = 0;
        rx_left       = 0;
        rx_stall_run  = 0;
        rx_cycle      = 0;
        no_result     = '0;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table: empty-table miss, appends, duplicate, both methods, full table
        add_row(1, METHOD_MTF, OP_SEARCH, 32'h0000_0000, 1, STATUS_MISS, 0);
        add_row(0, 0, OP_APPEND, 32'h0000_0000, 1, STATUS_APPENDED, 0);
        add_row(0, 0, OP_APPEND, 32'hFFFF_FFFF, 1, STATUS_APPENDED, 1);
        add_row(0, 0, OP_SEARCH, 32'hFFFF_FFFF, 0, 0, 0);
        add_row(0, 0, OP_SEARCH, 32'h0000_0000, 0, 0, 0);
        add_row(0, 0, OP_APPEND, 32'hFFFF_FFFF, 1, STATUS_APPENDED, 2);
        add_row(0, 0, OP_SEARCH, 32'hFFFF_FFFF, 0, 0, 0);
        add_row(0, 0, OP_SEARCH, 32'h1234_5678, 1, STATUS_MISS, 0);
        add_row(1, METHOD_TRANSPOSE, OP_APPEND, 32'h8000_0000, 0, 0, 0);
        add_row(0, 0, OP_SEARCH, 32'h8000_0000, 0, 0, 0);
        add_row(0, 0, OP_SEARCH, 32'h0000_0000, 0, 0, 0);
        for (i = 0; i < 12; i++) add_row(0, 0, OP_APPEND, 32'hA5A5_0000 | i, 0, 0, 0);
        add_row(0, 0, OP_APPEND, 32'h0000_0007, 1, STATUS_FULL, 0);
        add_row(0, 0, OP_SEARCH, 32'hA5A5_000B, 0, 0, 0);

        foreach (directed_rows[n]) begin
            if (directed_rows[n].cfg_write) set_method(directed_rows[n].cfg_method);
            send_lookup(directed_rows[n].op, directed_rows[n].key, directed_rows[n].typed,
                        directed_rows[n].typed_result);
            pause_sender($urandom_range(0, 3));
        end

        // Random phases on the filled table, alternating the method
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            set_method((phase % 2 == 0) ? METHOD_MTF : METHOD_TRANSPOSE);
            sent = 0;
            while (sent < RANDOM_PER_PHASE) begin
                burst = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 24);
                for (k = 0; k < burst && sent < RANDOM_PER_PHASE; k++) begin
                    r   = $urandom_range(0, 99);
                    op  = OP_SEARCH;
                    key = $urandom;
                    sel = (shadow_count > 0) ? $urandom_range(0, shadow_count - 1) : 0;
                    if (r < 65 && shadow_count > 0) begin
                        key = shadow_keys[sel];
                    end else if (r < 80) begin
                        key = $urandom;
                    end else if (r < 88 && shadow_count > 0) begin
                        // near miss: one bit off a stored key
                        key = shadow_keys[sel] ^ (32'h1 << $urandom_range(0, 31));
                    end else if (r < 95) begin
                        op = OP_APPEND;
                    end else begin
                        key = ($urandom_range(0, 1) == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
                    end
                    send_lookup(op, key, 0, no_result);
                    sent++;
                end
                pause_sender($urandom_range(0, 12));
            end
        end

        // Drain and let the block settle
        pause_sender(1);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sols_pkg.sv
rtl/sols_table.sv
rtl/self_organizing_list_search.sv
bench/tb_self_organizing_list_search.sv
